### design/glyph_to_rgb565_stream_macros.svh
// ----------------------------------------------------------------------------
// glyph_to_rgb565_stream_macros.svh
// Assertion macros shared by the checker of the glyph renderer.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TO_RGB565_STREAM_MACROS_SVH
`define GLYPH_TO_RGB565_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GTR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication that is checked at every edge, reset included.
`define GTR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

### design/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Constants and types shared by the glyph renderer modules.
// ----------------------------------------------------------------------------
package gtr_pkg;

   localparam int COORD_W = 8;
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 8;
   localparam int GLYPH_W = GLYPH_COLS * GLYPH_ROWS;

   // Controller command bytes.
   localparam logic [7:0] CMD_COL_SET = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET = 8'h2B;
   localparam logic [7:0] CMD_MEM_WR  = 8'h2C;

   // Sequence steps of one request.
   typedef logic [5:0] step_type;
   localparam step_type STEP_COL_CMD   = 6'd0;
   localparam step_type STEP_COL_START = 6'd1;
   localparam step_type STEP_COL_END   = 6'd2;
   localparam step_type STEP_ROW_CMD   = 6'd3;
   localparam step_type STEP_ROW_START = 6'd4;
   localparam step_type STEP_ROW_END   = 6'd5;
   localparam step_type STEP_MEM_CMD   = 6'd6;
   localparam step_type STEP_LAST      = 6'd54;

   // Cell geometry as counter values.
   localparam logic [2:0] CELL_LAST_COL = 3'd5;
   localparam logic [2:0] CELL_LAST_ROW = 3'd7;

   localparam logic [COORD_W-1:0] COL_SPAN = 8'd5;
   localparam logic [COORD_W-1:0] ROW_SPAN = 8'd7;

   typedef struct packed {
      logic                is_command;
      logic                is_word;
      logic [COLOR_W-1:0]  value;
      logic                last_of_run;
   } rsp_type;

endpackage

### design/gtr_req_if.sv
// ----------------------------------------------------------------------------
// gtr_req_if
// Request channel: one character to draw per handshake.
// ----------------------------------------------------------------------------
interface gtr_req_if;
   import gtr_pkg::*;

   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  pos_x;
   logic [COORD_W-1:0]  pos_y;
   logic [CODE_W-1:0]   char_code;
   logic [COLOR_W-1:0]  fg_color;
   logic [COLOR_W-1:0]  bg_color;

   modport source (output valid, pos_x, pos_y, char_code, fg_color, bg_color,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, char_code, fg_color, bg_color,
                   output ready);
endinterface

### design/gtr_rsp_if.sv
// ----------------------------------------------------------------------------
// gtr_rsp_if
// Response channel: one controller command or data word per handshake.
// ----------------------------------------------------------------------------
interface gtr_rsp_if;
   import gtr_pkg::*;

   logic                valid;
   logic                ready;
   logic                is_command;
   logic                is_word;
   logic [COLOR_W-1:0]  value;
   logic                last_of_run;

   modport source (output valid, is_command, is_word, value, last_of_run,
                   input ready);
   modport sink   (input valid, is_command, is_word, value, last_of_run,
                   output ready);
endinterface

### design/glyph_to_rgb565_stream.sv
// ----------------------------------------------------------------------------
// glyph_to_rgb565_stream
// Turns one character request into the 55-word display controller stream.
// ----------------------------------------------------------------------------
// Flow: an accepted request waits in the pending slot, is loaded into the
// active registers and then has its first word registered in the output
// register; the 55 words follow one per cycle while the receiver keeps ready
// high, and a pending request follows the last pixel without a gap.
// Reset: synchronous, active high; clears the pending and active requests
// and the response valid flag.
module glyph_to_rgb565_stream
   import gtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gtr_req_if.sink    req_chan,
   gtr_rsp_if.source  rsp_chan
);

   // A single pending slot holds the next request while the current one is
   // still being streamed out, so requests are taken without waiting for
   // the response side to drain.
   logic                pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0]  pend_x_ff, pend_y_ff;
   logic [CODE_W-1:0]   pend_code_ff;
   logic [COLOR_W-1:0]  pend_fg_ff, pend_bg_ff;

   // Request that is currently being drawn.
   logic                active_ff, active_in;
   step_type            step_ff, step_in;
   logic [2:0]          col_ff, col_in;
   logic [2:0]          row_ff, row_in;
   logic [COORD_W-1:0]  cur_x_ff, cur_y_ff;
   logic [COLOR_W-1:0]  cur_fg_ff, cur_bg_ff;

   // Response output register.
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_accept;
   logic                advance;
   logic                load;
   logic                lit;
   logic [GLYPH_W-1:0]  glyph_bits;

   assign req_chan.ready = !pend_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The sequencer moves one step whenever the output register is free or
   // is being emptied in this cycle.
   assign advance = active_ff && (!rsp_valid_ff || rsp_chan.ready);

   // The pending request starts when nothing is active or when the active
   // request hands over its final pixel.
   assign load = pend_valid_ff && (!active_ff || (advance && step_ff == STEP_LAST));

   // The glyph bitmap is read from the font ROM when a request starts. The ROM
   // registers it as the sequencer loads, well before the first pixel step, and
   // it holds until the next request starts after the last pixel.
   gtr_font_rom u_font_rom (
      .clock      (clock),
      .rd_en      (load),
      .rd_code    (pend_code_ff),
      .rd_bits_ff (glyph_bits)
   );

   // Column five and row seven are the spacing and are always background.
   always_comb begin
      lit = 1'b0;
      if (col_ff != CELL_LAST_COL && row_ff != CELL_LAST_ROW) begin
         lit = glyph_bits[{col_ff, row_ff}];
      end
   end

   // Response word for the current step.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.is_command  = 1'b0;
      rsp_in.is_word     = 1'b1;
      rsp_in.last_of_run = 1'b0;
      priority if (step_ff == STEP_COL_CMD) begin
         rsp_in.is_command = 1'b1;
         rsp_in.is_word    = 1'b0;
         rsp_in.value      = {8'h00, CMD_COL_SET};
      end else if (step_ff == STEP_COL_START) begin
         rsp_in.value = {8'h00, cur_x_ff};
      end else if (step_ff == STEP_COL_END) begin
         rsp_in.value = {8'h00, cur_x_ff + COL_SPAN};
      end else if (step_ff == STEP_ROW_CMD) begin
         rsp_in.is_command = 1'b1;
         rsp_in.is_word    = 1'b0;
         rsp_in.value      = {8'h00, CMD_ROW_SET};
      end else if (step_ff == STEP_ROW_START) begin
         rsp_in.value = {8'h00, cur_y_ff};
      end else if (step_ff == STEP_ROW_END) begin
         rsp_in.value = {8'h00, cur_y_ff + ROW_SPAN};
      end else if (step_ff == STEP_MEM_CMD) begin
         rsp_in.is_command = 1'b1;
         rsp_in.is_word    = 1'b0;
         rsp_in.value      = {8'h00, CMD_MEM_WR};
      end else begin
         rsp_in.value       = lit ? cur_fg_ff : cur_bg_ff;
         rsp_in.last_of_run = (step_ff == STEP_LAST);
      end
   end

   // Next state of the sequencer. Pixels run row by row, left to right.
   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (load) begin
         active_in = 1'b1;
         step_in   = STEP_COL_CMD;
         col_in    = '0;
         row_in    = '0;
      end else if (advance) begin
         if (step_ff == STEP_LAST) begin
            active_in = 1'b0;
         end else begin
            step_in = step_ff + 6'd1;
            if (step_ff > STEP_MEM_CMD) begin
               if (col_ff == CELL_LAST_COL) begin
                  col_in = '0;
                  row_in = row_ff + 3'd1;
               end else begin
                  col_in = col_ff + 3'd1;
               end
            end
         end
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_accept) begin
         pend_valid_in = 1'b1;
      end else if (load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= STEP_COL_CMD;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_x_ff    <= req_chan.pos_x;
         pend_y_ff    <= req_chan.pos_y;
         pend_code_ff <= req_chan.char_code;
         pend_fg_ff   <= req_chan.fg_color;
         pend_bg_ff   <= req_chan.bg_color;
      end
      if (load) begin
         cur_x_ff  <= pend_x_ff;
         cur_y_ff  <= pend_y_ff;
         cur_fg_ff <= pend_fg_ff;
         cur_bg_ff <= pend_bg_ff;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.is_command  = rsp_ff.is_command;
   assign rsp_chan.is_word     = rsp_ff.is_word;
   assign rsp_chan.value       = rsp_ff.value;
   assign rsp_chan.last_of_run = rsp_ff.last_of_run;

endmodule

### design/gtr_font_rom.sv
// ----------------------------------------------------------------------------
// gtr_font_rom
// Synchronous 5x7 font ROM: one whole glyph of five column bitmaps per read.
// ----------------------------------------------------------------------------
module gtr_font_rom
   import gtr_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [CODE_W-1:0]   rd_code,
   output logic [GLYPH_W-1:0]  rd_bits_ff
);

   localparam int GLYPH_COUNT = 22;

   // Each entry: character code, then columns 4..0 (column 0 in the low byte).
   localparam logic [CODE_W+GLYPH_W-1:0] FONT_MEM [GLYPH_COUNT] = '{
      {8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      {8'h30, 8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E},
      {8'h31, 8'h00, 8'h40, 8'h7F, 8'h42, 8'h00},
      {8'h32, 8'h46, 8'h49, 8'h51, 8'h61, 8'h42},
      {8'h33, 8'h31, 8'h4B, 8'h45, 8'h41, 8'h21},
      {8'h34, 8'h10, 8'h7F, 8'h12, 8'h14, 8'h18},
      {8'h35, 8'h39, 8'h45, 8'h45, 8'h45, 8'h27},
      {8'h36, 8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C},
      {8'h37, 8'h03, 8'h05, 8'h09, 8'h71, 8'h01},
      {8'h38, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
      {8'h39, 8'h1E, 8'h29, 8'h49, 8'h49, 8'h06},
      {8'h41, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
      {8'h42, 8'h36, 8'h49, 8'h49, 8'h49, 8'h7F},
      {8'h43, 8'h22, 8'h41, 8'h41, 8'h41, 8'h3E},
      {8'h44, 8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F},
      {8'h45, 8'h41, 8'h49, 8'h49, 8'h49, 8'h7F},
      {8'h46, 8'h01, 8'h09, 8'h09, 8'h09, 8'h7F},
      {8'h2A, 8'h14, 8'h08, 8'h3E, 8'h08, 8'h14},
      {8'h23, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
      {8'h3A, 8'h00, 8'h00, 8'h36, 8'h36, 8'h00},
      {8'h2E, 8'h00, 8'h00, 8'h60, 8'h60, 8'h00},
      {8'h2D, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08}
   };

   logic [GLYPH_W-1:0] rd_bits_in;

   // Codes are unique, so OR-ing the matching entries selects one glyph.
   // A code without an entry yields all zeros, which draws a space.
   always_comb begin
      rd_bits_in = '0;
      for (int i = 0; i < GLYPH_COUNT; i++) begin
         if (FONT_MEM[i][CODE_W+GLYPH_W-1:GLYPH_W] == rd_code) begin
            rd_bits_in = rd_bits_in | FONT_MEM[i][GLYPH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_bits_ff <= rd_bits_in;
      end
   end

endmodule

### design/gtr_checker.sv
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks of the glyph renderer's response stream.
// ----------------------------------------------------------------------------
`include "glyph_to_rgb565_stream_macros.svh"

module gtr_checker
   import gtr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_is_command,
   input  logic                rsp_is_word,
   input  logic [COLOR_W-1:0]  rsp_value,
   input  logic                rsp_last_of_run
);

   `GTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_last_of_run), "stalled response changed")
   `GTR_ASSERT_IMP(a_cmd_code, clock, reset, rsp_valid && rsp_is_command, !rsp_is_word && !rsp_last_of_run && (rsp_value == {8'h00, CMD_COL_SET} || rsp_value == {8'h00, CMD_ROW_SET} || rsp_value == {8'h00, CMD_MEM_WR}), "bad command word")
   `GTR_ASSERT_IMP(a_last_is_pixel, clock, reset, rsp_valid && rsp_last_of_run, rsp_is_word && !rsp_is_command, "last flag on a non-pixel word")
   `GTR_ASSERT_NEXT(a_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last_of_run, !rsp_valid || (rsp_is_command && rsp_value == {8'h00, CMD_COL_SET}), "stream after last pixel does not start with column set")
   `GTR_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind glyph_to_rgb565_stream gtr_checker u_gtr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_is_command  (rsp_chan.is_command),
   .rsp_is_word     (rsp_chan.is_word),
   .rsp_value       (rsp_chan.value),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

### tb/sv/glyph_stream_checker.sv
// ----------------------------------------------------------------------------
// glyph_stream_checker
// Watches both channels of the glyph renderer. For each accepted request it
// builds the 55 stream words that must follow. Each accepted response word is
// compared field by field with the oldest word still owed.
// ----------------------------------------------------------------------------
module glyph_stream_checker
   import gtr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gtr_req_if   req_mon,
   gtr_rsp_if   rsp_mon,
   output int   failures,
   output int   words_waiting,
   output int   chars_drawn,
   output int   words_checked,
   output int   blank_chars,
   output int   wrapped_chars
);

   rsp_type owed_words[$];

   initial begin
      failures      = 0;
      words_waiting = 0;
      chars_drawn   = 0;
      words_checked = 0;
      blank_chars   = 0;
      wrapped_chars = 0;
   end

   // Bit 40 flags a code that has a glyph; column c sits in bits [8c +: 8],
   // and bit r of a column lights row r.
   function automatic logic [40:0] font_lookup(input logic [CODE_W-1:0] code);
      case (code)
         8'h20: font_lookup = {1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         8'h30: font_lookup = {1'b1, 8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         8'h31: font_lookup = {1'b1, 8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         8'h32: font_lookup = {1'b1, 8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         8'h33: font_lookup = {1'b1, 8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         8'h34: font_lookup = {1'b1, 8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         8'h35: font_lookup = {1'b1, 8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         8'h36: font_lookup = {1'b1, 8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         8'h37: font_lookup = {1'b1, 8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         8'h38: font_lookup = {1'b1, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: font_lookup = {1'b1, 8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         8'h41: font_lookup = {1'b1, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         8'h42: font_lookup = {1'b1, 8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h43: font_lookup = {1'b1, 8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h44: font_lookup = {1'b1, 8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
         8'h45: font_lookup = {1'b1, 8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h46: font_lookup = {1'b1, 8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
         8'h2A: font_lookup = {1'b1, 8'h14, 8'h08, 8'h3E, 8'h08, 8'h14};
         8'h23: font_lookup = {1'b1, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
         8'h3A: font_lookup = {1'b1, 8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
         8'h2E: font_lookup = {1'b1, 8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         8'h2D: font_lookup = {1'b1, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         default: font_lookup = '0;
      endcase
   endfunction

   function automatic rsp_type make_word(input logic cmd, input logic wide,
                                         input logic [COLOR_W-1:0] value,
                                         input logic last);
      rsp_type word;
      word.is_command  = cmd;
      word.is_word     = wide;
      word.value       = value;
      word.last_of_run = last;
      return word;
   endfunction

   task automatic queue_char_stream(input logic [COORD_W-1:0] x, y,
                                    input logic [CODE_W-1:0] code,
                                    input logic [COLOR_W-1:0] fg, bg);
      logic [40:0]        glyph;
      logic [COORD_W-1:0] col_end;
      logic [COORD_W-1:0] row_end;
      logic               lit;
      glyph   = font_lookup(code);
      col_end = x + COL_SPAN;
      row_end = y + ROW_SPAN;
      if (!glyph[40]) blank_chars++;
      if (col_end < x || row_end < y) wrapped_chars++;
      owed_words.push_back(make_word(1'b1, 1'b0, {8'h00, CMD_COL_SET}, 1'b0));
      owed_words.push_back(make_word(1'b0, 1'b1, {8'h00, x}, 1'b0));
      owed_words.push_back(make_word(1'b0, 1'b1, {8'h00, col_end}, 1'b0));
      owed_words.push_back(make_word(1'b1, 1'b0, {8'h00, CMD_ROW_SET}, 1'b0));
      owed_words.push_back(make_word(1'b0, 1'b1, {8'h00, y}, 1'b0));
      owed_words.push_back(make_word(1'b0, 1'b1, {8'h00, row_end}, 1'b0));
      owed_words.push_back(make_word(1'b1, 1'b0, {8'h00, CMD_MEM_WR}, 1'b0));
      // The spacing column and row never light.
      for (int row = 0; row <= CELL_LAST_ROW; row++) begin
         for (int col = 0; col <= CELL_LAST_COL; col++) begin
            lit = (col < CELL_LAST_COL) && (row < CELL_LAST_ROW) && glyph[8*col + row];
            owed_words.push_back(make_word(1'b0, 1'b1, lit ? fg : bg,
               (row == CELL_LAST_ROW) && (col == CELL_LAST_COL)));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            queue_char_stream(req_mon.pos_x, req_mon.pos_y, req_mon.char_code,
                              req_mon.fg_color, req_mon.bg_color);
            chars_drawn++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = make_word(rsp_mon.is_command, rsp_mon.is_word, rsp_mon.value,
                            rsp_mon.last_of_run);
            if (owed_words.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected word: cmd=%0b word=%0b value=%h last=%0b",
                           got.is_command, got.is_word, got.value, got.last_of_run);
            end else begin
               want = owed_words.pop_front();
               words_checked++;
               if (got.is_command !== want.is_command || got.is_word !== want.is_word ||
                   got.value !== want.value || got.last_of_run !== want.last_of_run) begin
                  failures++;
                  if (failures <= 10)
                     $display("word mismatch: expected cmd=%0b word=%0b value=%h last=%0b, got cmd=%0b word=%0b value=%h last=%0b",
                              want.is_command, want.is_word, want.value, want.last_of_run,
                              got.is_command, got.is_word, got.value, got.last_of_run);
               end
            end
         end
      end
      words_waiting <= owed_words.size();
   end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives character requests into the glyph renderer and collects its stream.
// A directed set covers every glyph, unknown codes and window wrap at the
// display edge; random requests then run under several idling patterns and
// one long response stall. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module testbench;
   import gtr_pkg::*;

   // Generous bound: 370 requests of 55 words each stay far below this, even
   // under heavy stalls.
   localparam int CYCLE_LIMIT  = 300000;
   // Length of the response hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES  = 400;
   // Extra watch time for stray words once every owed word has arrived.
   localparam int DRAIN_CYCLES = 20;

   // Every character code that has a glyph in the font.
   localparam logic [CODE_W-1:0] GLYPH_CODES [22] = '{
      8'h20, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h2A, 8'h23, 8'h3A, 8'h2E, 8'h2D
   };

   logic clock;
   logic reset;

   gtr_req_if req_chan ();
   gtr_rsp_if rsp_chan ();

   // Idling knobs, in percent of cycles, changed between phases.
   int   send_idle_pct;
   int   rsp_stall_pct;
   // The long hold-off is started by the stimulus but timed by its own process.
   logic hold_go;
   logic rsp_hold;
   int   cycle_count;

   int   failures;
   int   words_waiting;
   int   chars_drawn;
   int   words_checked;
   int   blank_chars;
   int   wrapped_chars;

   glyph_to_rgb565_stream dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   glyph_stream_checker stream_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .failures      (failures),
      .words_waiting (words_waiting),
      .chars_drawn   (chars_drawn),
      .words_checked (words_checked),
      .blank_chars   (blank_chars),
      .wrapped_chars (wrapped_chars)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words still owed",
                  cycle_count, words_waiting);
         $display("status: fail");
         $finish;
      end
   end

   // The receiver stalls at random, and throughout while the hold-off runs.
   // Ready changes only at the falling edge so the block sees it settled.
   always @(negedge clock) begin
      rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Long hold-off: once asked for, the receiver keeps ready low for
   // HOLD_CYCLES while the sender keeps offering requests. The block
   // fills its pending slot and must hold off its own input.
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Offers one request. Idle cycles, if any, come first and hold valid low;
   // when there are none, valid simply stays high from the previous request,
   // so no falling edge carries more than one update of valid.
   task automatic offer_char(input logic [COORD_W-1:0] x, y,
                             input logic [CODE_W-1:0] code,
                             input logic [COLOR_W-1:0] fg, bg);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.pos_x     <= x;
      req_chan.pos_y     <= y;
      req_chan.char_code <= code;
      req_chan.fg_color  <= fg;
      req_chan.bg_color  <= bg;
      // The request is taken at the first rising edge that sees ready high.
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Random request: mostly real glyphs, the rest any byte, which reaches
   // the unknown codes. Each coordinate is near the right or bottom edge one
   // time in five, so the window end can wrap around.
   task automatic random_char();
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      code = ($urandom_range(9) < 7) ? GLYPH_CODES[$urandom_range(21)]
                                     : CODE_W'($urandom);
      x = ($urandom_range(4) == 0) ? COORD_W'($urandom_range(255, 248))
                                   : COORD_W'($urandom);
      y = ($urandom_range(4) == 0) ? COORD_W'($urandom_range(255, 248))
                                   : COORD_W'($urandom);
      offer_char(x, y, code, COLOR_W'($urandom), COLOR_W'($urandom));
   endtask

   task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) random_char();
   endtask

   initial begin
      int idx;
      // Every input is known from time zero, and reset starts high.
      reset              = 1'b1;
      hold_go            = 1'b0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      req_chan.valid     = 1'b0;
      req_chan.pos_x     = '0;
      req_chan.pos_y     = '0;
      req_chan.char_code = '0;
      req_chan.fg_color  = '0;
      req_chan.bg_color  = '0;
      rsp_chan.ready     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with no idling. Every glyph once: the first at the
      // top-left corner with all-ones on all-zeros, the second at the
      // bottom-right corner where both window ends wrap, with the colors
      // swapped, and the rest with mixed bit patterns.
      for (idx = 0; idx < 22; idx++) begin
         if (idx == 0)
            offer_char(8'd0, 8'd0, GLYPH_CODES[idx], 16'hFFFF, 16'h0000);
         else if (idx == 1)
            offer_char(8'd255, 8'd255, GLYPH_CODES[idx], 16'h0000, 16'hFFFF);
         else if (idx[0])
            offer_char(COORD_W'(idx * 11), COORD_W'(250 - idx), GLYPH_CODES[idx],
                       16'hAAAA, 16'h5555);
         else
            offer_char(COORD_W'(255 - idx), COORD_W'(idx * 7), GLYPH_CODES[idx],
                       16'h5555, 16'hAAAA);
      end
      // Codes without a glyph must draw as a blank cell: the lowest code, the
      // first of the upper half and the highest.
      offer_char(8'd10, 8'd20, 8'h00, 16'hF800, 16'h07E0);
      offer_char(8'd251, 8'd248, 8'h80, 16'h001F, 16'hFFE0);
      offer_char(8'd128, 8'd249, 8'hFF, 16'hFFFF, 16'h0000);

      // Random part under each idling pattern in turn.
      random_phase(60, 0, 0);
      random_phase(70, 57, 0);
      random_phase(70, 0, 57);
      random_phase(70, 19, 19);

      // Back-pressure: the receiver holds off for a long stretch while
      // requests keep coming with no gaps.
      hold_go = 1'b1;
      random_phase(30, 0, 0);

      random_phase(45, 0, 0);

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Let every owed word arrive, then watch a little longer for strays.
      while (words_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("drew %0d characters (%0d blank for unknown codes, %0d with a wrapped window)",
               chars_drawn, blank_chars, wrapped_chars);
      $display("compared %0d stream words across four idling patterns and one long stall",
               words_checked);
      if (words_waiting != 0)
         $display("%0d stream words never arrived", words_waiting);
      if (failures == 0 && words_waiting == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
